// ----- rtl/core/ipv4dq_pkg.sv -----
package ipv4dq_pkg;

    // Character codes of interest
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Address format limits
    localparam logic [9:0] OCTET_MAX     = 10'd255;
    localparam logic [2:0] DOTS_PER_ADDR = 3'd3;
    localparam logic [1:0] DIGITS_MAX    = 2'd3;

    // One result word
    typedef struct packed {
        logic        addr_valid;
        logic [31:0] address;
    } result_t;

endpackage

// ----- rtl/core/ipv4_dotted_quad_parser.sv -----
// When the output word is free, a result shows on out_valid in the cycle after its zero byte.
// Throughput: one character per cycle unless in_stall; the parse state is updated by a single
// multiply-by-ten add and a few compares between the state registers and the result register.
// A two-word output buffer (result register plus skid register) lets characters keep
// flowing while a result waits; in_stall rises only when both words are full.
// Reset (rst_n low, asynchronous): parse state cleared, both output words empty.
module ipv4_dotted_quad_parser
    import ipv4dq_pkg::*;
#(
    parameter int MAX_CHARS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        addr_valid,
    output logic [31:0] address
);

    localparam int CW = $clog2(MAX_CHARS + 1);

    // Parse state
    logic [9:0]    octet_value_reg, octet_value_next;
    logic [1:0]    digit_count_reg, digit_count_next;
    logic [2:0]    dot_count_reg, dot_count_next;
    logic [CW-1:0] char_count_reg, char_count_next;
    logic [31:0]   address_shift_reg, address_shift_next;
    logic          parse_error_reg, parse_error_next;

    // Output buffer
    logic          out_valid_reg, out_valid_next;
    result_t       out_word_reg, out_word_next;
    logic          skid_valid_reg, skid_valid_next;
    result_t       skid_word_reg, skid_word_next;

    logic          in_fire;
    logic          res_push;
    logic          out_pop;
    logic          octet_ok;
    logic [9:0]    octet_times10;
    result_t       res_word;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !in_stall;
    assign out_pop  = out_valid_reg && !out_stall;
    assign res_push = in_fire && (char_byte == CHAR_NUL);

    assign octet_ok      = (digit_count_reg != 2'd0) && (octet_value_reg <= OCTET_MAX);
    assign octet_times10 = {octet_value_reg[6:0], 3'b000} + {octet_value_reg[8:0], 1'b0};

    // Result of a terminating zero byte
    always_comb
    begin
        res_word.addr_valid = !parse_error_reg && octet_ok && (dot_count_reg == DOTS_PER_ADDR);
        res_word.address    = res_word.addr_valid ?
                              {address_shift_reg[23:0], octet_value_reg[7:0]} : 32'd0;
    end

    // Per-character state update
    always_comb
    begin
        octet_value_next   = octet_value_reg;
        digit_count_next   = digit_count_reg;
        dot_count_next     = dot_count_reg;
        char_count_next    = char_count_reg;
        address_shift_next = address_shift_reg;
        parse_error_next   = parse_error_reg;
        if (in_fire)
        begin
            if (char_byte == CHAR_NUL)
            begin
                octet_value_next   = 10'd0;
                digit_count_next   = 2'd0;
                dot_count_next     = 3'd0;
                char_count_next    = '0;
                address_shift_next = 32'd0;
                parse_error_next   = 1'b0;
            end
            else if (!parse_error_reg)
            begin
                if (char_count_reg >= CW'(MAX_CHARS))
                begin
                    parse_error_next = 1'b1;
                end
                else
                begin
                    char_count_next = char_count_reg + 1'b1;
                    if (char_byte inside {[CHAR_ZERO:CHAR_NINE]})
                    begin
                        if (digit_count_reg >= DIGITS_MAX)
                        begin
                            parse_error_next = 1'b1;
                        end
                        else
                        begin
                            octet_value_next = octet_times10 + {6'd0, char_byte[3:0]};
                            digit_count_next = digit_count_reg + 1'b1;
                        end
                    end
                    else if (char_byte == CHAR_DOT)
                    begin
                        if ((dot_count_reg >= DOTS_PER_ADDR) || !octet_ok)
                        begin
                            parse_error_next = 1'b1;
                        end
                        else
                        begin
                            address_shift_next = {address_shift_reg[23:0],
                                                  octet_value_reg[7:0]};
                            octet_value_next   = 10'd0;
                            digit_count_next   = 2'd0;
                            dot_count_next     = dot_count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        parse_error_next = 1'b1;
                    end
                end
            end
        end
    end

    // Output register with skid word behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_push)
        begin
            if (!out_valid_reg || out_pop)
            begin
                out_valid_next = 1'b1;
                out_word_next  = res_word;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_word_next  = res_word;
            end
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octet_value_reg   <= 10'd0;
            digit_count_reg   <= 2'd0;
            dot_count_reg     <= 3'd0;
            char_count_reg    <= '0;
            address_shift_reg <= 32'd0;
            parse_error_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            octet_value_reg   <= octet_value_next;
            digit_count_reg   <= digit_count_next;
            dot_count_reg     <= dot_count_next;
            char_count_reg    <= char_count_next;
            address_shift_reg <= address_shift_next;
            parse_error_reg   <= parse_error_next;
            out_valid_reg     <= out_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_valid  = out_valid_reg;
    assign addr_valid = out_word_reg.addr_valid;
    assign address    = out_word_reg.address;

    // Checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held while output word empty");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (char_count_reg == '0) && (dot_count_reg == 3'd0) && !parse_error_reg)
        else $error("parse state not cleared after end of string");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_word_reg.addr_valid) |-> (out_word_reg.address == 32'd0))
        else $error("invalid result carries nonzero address");

    a_empty_octet: assert property (@(posedge clk) disable iff (!rst_n)
        (digit_count_reg == 2'd0) |-> (octet_value_reg == 10'd0))
        else $error("octet accumulator nonzero with no digits");

endmodule
